// ===== hdl/vcf_pkg.sv =====
// package: shared types, register indexes and constants for the vertex color fixup
`timescale 1ns / 1ps

package vcf_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned IdxW   = 16;
    localparam int unsigned SplitW = 17;
    localparam int unsigned RegIdxW = 3;

    // floor(y / 255) for y below 2^15 as (y * Recip255) >> Recip255Shift
    localparam logic [15:0] Recip255      = 16'h8081;
    localparam int unsigned Recip255Shift = 23;

    typedef enum logic [RegIdxW-1:0] {
        REG_AMBIENT_RED       = 3'd0,
        REG_AMBIENT_GREEN     = 3'd1,
        REG_AMBIENT_BLUE      = 3'd2,
        REG_SKIP_BASE_COLOR   = 3'd3,
        REG_LIGHTEN_INTERIORS = 3'd4,
        REG_EXTERIOR_GROUP    = 3'd5,
        REG_SPLIT_INDEX       = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_LOWER = 2'd1,
        MODE_UPPER = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ChanW-1:0]  ambient_red;
        logic [ChanW-1:0]  ambient_green;
        logic [ChanW-1:0]  ambient_blue;
        logic              skip_base_color;
        logic              lighten_interiors;
        logic              exterior_group;
        logic [SplitW-1:0] split_index;
    } t_cfg;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

endpackage

// ===== hdl/vcf_if.sv =====
// interfaces: vertex request, color result and configuration write channels
`timescale 1ns / 1ps

interface vcf_in_if;
    import vcf_pkg::*;
    logic             valid;
    logic             ready;
    logic [IdxW-1:0]  vertex_index;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
    modport source (output valid, vertex_index, in_red, in_green, in_blue, in_alpha,
                    input ready);
    modport sink (input valid, vertex_index, in_red, in_green, in_blue, in_alpha,
                  output ready);
endinterface

interface vcf_out_if;
    import vcf_pkg::*;
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface vcf_cfg_if;
    import vcf_pkg::*;
    logic               valid;
    logic               ready;
    logic [RegIdxW-1:0] index;
    logic [SplitW-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/vcf_cfg_regs.sv =====
// configuration register file
`timescale 1ns / 1ps

module vcf_cfg_regs
    import vcf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vcf_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_AMBIENT_RED:       n_cfg.ambient_red       = i_cfg.data[ChanW-1:0];
                REG_AMBIENT_GREEN:     n_cfg.ambient_green     = i_cfg.data[ChanW-1:0];
                REG_AMBIENT_BLUE:      n_cfg.ambient_blue      = i_cfg.data[ChanW-1:0];
                REG_SKIP_BASE_COLOR:   n_cfg.skip_base_color   = i_cfg.data[0];
                REG_LIGHTEN_INTERIORS: n_cfg.lighten_interiors = i_cfg.data[0];
                REG_EXTERIOR_GROUP:    n_cfg.exterior_group    = i_cfg.data[0];
                REG_SPLIT_INDEX:       n_cfg.split_index       = i_cfg.data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hdl/vcf_chan.sv =====
// one color channel datapath, three register stages
`timescale 1ns / 1ps

module vcf_chan
    import vcf_pkg::*;
(
    input  logic             i_clk,
    input  t_pipe_en         i_en,
    input  logic [ChanW-1:0] i_c,
    input  logic [ChanW-1:0] i_m,
    input  logic [ChanW-1:0] i_a,
    input  t_mode            i_mode,
    output logic [ChanW-1:0] o_res
);

    localparam int unsigned ProdW = 2 * ChanW;
    localparam int unsigned CaW   = ProdW - 6;
    localparam int unsigned TW    = CaW + 2;
    localparam int unsigned YW    = ProdW - 1;
    localparam int unsigned QW    = YW + 16;

    // stage 1
    logic [ChanW-1:0] r_c1;
    logic [ChanW-1:0] r_m1;
    logic [ChanW-1:0] r_a1;
    logic [ChanW-1:0] r_d1;
    logic [ChanW-1:0] r_na1;
    // stage 2
    logic [ProdW-1:0] r_lp2;
    logic [CaW-1:0]   r_ca2;
    logic [ChanW-1:0] r_c2;
    logic [ChanW-1:0] r_m2;
    // stage 3
    logic [ChanW-1:0] r_res3;

    logic [ProdW-1:0] n_lp2;
    logic [ProdW-1:0] n_ca_full;
    logic [YW-1:0]    n_y;
    logic [QW-1:0]    n_q;
    logic [TW-1:0]    n_t;
    logic [TW-2:0]    n_h;
    logic [ChanW-1:0] n_lower;
    logic [ChanW-1:0] n_upper;
    logic [ChanW-1:0] n_res3;

    assign n_lp2     = r_d1 * r_na1;
    assign n_ca_full = r_c1 * r_a1;

    // lower: floor(p / 510) == floor((p >> 1) / 255)
    assign n_y     = r_lp2[ProdW-1:1];
    assign n_q     = n_y * Recip255;
    assign n_lower = n_q[Recip255Shift +: ChanW];

    // upper: clamp((c*a/64 + c - m) / 2)
    assign n_t = {2'b00, r_ca2} + {{(TW-ChanW){1'b0}}, r_c2}
               - {{(TW-ChanW){1'b0}}, r_m2};
    assign n_h = n_t[TW-1:1];
    always_comb begin
        if (n_t[TW-1]) begin
            n_upper = '0;
        end else if (n_h > (TW-1)'(255)) begin
            n_upper = '1;
        end else begin
            n_upper = n_h[ChanW-1:0];
        end
    end

    always_comb begin
        unique case (i_mode)
            MODE_LOWER: n_res3 = n_lower;
            MODE_UPPER: n_res3 = n_upper;
            MODE_PASS:  n_res3 = r_c2;
            default:    n_res3 = r_c2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_c1  <= i_c;
            r_m1  <= i_m;
            r_a1  <= i_a;
            r_d1  <= i_c - i_m;
            r_na1 <= ~i_a;
        end
        if (i_en.s2) begin
            r_lp2 <= n_lp2;
            r_ca2 <= n_ca_full[ProdW-1:6];
            r_c2  <= r_c1;
            r_m2  <= r_m1;
        end
        if (i_en.s3) begin
            r_res3 <= n_res3;
        end
    end

    assign o_res = r_res3;

endmodule

// ===== hdl/vertex_color_fixup_core.sv =====
// top level: vertex color fixup, three stage pipeline
// an accepted request reaches result valid through the stage 1, 2 and 3 registers
// throughput: one vertex per cycle unless stalled, set by the three stage pipeline
// a stalled result holds only full stages; ready follows the downstream ready chain
// reset (synchronous, active low) clears stage valids and all config registers to 0
`timescale 1ns / 1ps

module vertex_color_fixup_core
    import vcf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vcf_in_if.sink    i_vtx,
    vcf_cfg_if.sink   i_cfg,
    vcf_out_if.source o_pix
);

    t_cfg     cfg;
    t_pipe_en en;

    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    t_mode            r_mode1;
    t_mode            r_mode2;
    t_mode            r_mode3;
    logic [ChanW-1:0] r_alpha1;
    logic [ChanW-1:0] r_alpha2;
    logic [ChanW-1:0] r_alpha3;

    logic             n_upper;
    t_mode            n_mode1;
    logic [ChanW-1:0] n_alpha1;
    logic [ChanW-1:0] n_fixed;
    logic [ChanW-1:0] m_r;
    logic [ChanW-1:0] m_g;
    logic [ChanW-1:0] m_b;

    vcf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign en.s3       = !r_v3 || o_pix.ready;
    assign en.s2       = !r_v2 || en.s3;
    assign en.s1       = !r_v1 || en.s2;
    assign i_vtx.ready = en.s1;

    assign n_upper = {1'b0, i_vtx.vertex_index} >= cfg.split_index;
    assign n_fixed = cfg.exterior_group ? '1 : '0;
    assign m_r     = cfg.skip_base_color ? '0 : cfg.ambient_red;
    assign m_g     = cfg.skip_base_color ? '0 : cfg.ambient_green;
    assign m_b     = cfg.skip_base_color ? '0 : cfg.ambient_blue;

    always_comb begin
        priority if (cfg.lighten_interiors) begin
            n_mode1 = MODE_PASS;
        end else if (n_upper) begin
            n_mode1 = MODE_UPPER;
        end else begin
            n_mode1 = MODE_LOWER;
        end
        n_alpha1 = n_upper ? n_fixed : i_vtx.in_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= i_vtx.valid;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_mode1  <= n_mode1;
            r_alpha1 <= n_alpha1;
        end
        if (en.s2) begin
            r_mode2  <= r_mode1;
            r_alpha2 <= r_alpha1;
        end
        if (en.s3) begin
            r_mode3  <= r_mode2;
            r_alpha3 <= r_alpha2;
        end
    end

    vcf_chan u_red (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_c    (i_vtx.in_red),
        .i_m    (m_r),
        .i_a    (i_vtx.in_alpha),
        .i_mode (r_mode2),
        .o_res  (o_pix.out_red)
    );

    vcf_chan u_green (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_c    (i_vtx.in_green),
        .i_m    (m_g),
        .i_a    (i_vtx.in_alpha),
        .i_mode (r_mode2),
        .o_res  (o_pix.out_green)
    );

    vcf_chan u_blue (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_c    (i_vtx.in_blue),
        .i_m    (m_b),
        .i_a    (i_vtx.in_alpha),
        .i_mode (r_mode2),
        .o_res  (o_pix.out_blue)
    );

    assign o_pix.valid     = r_v3;
    assign o_pix.out_alpha = r_alpha3;

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.ready |-> i_vtx.ready)
        else $error("input stalled while output is ready");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !o_pix.ready) |-> !i_vtx.ready)
        else $error("request taken into a full stalled pipeline");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("stage valid set after reset");

    a_upper_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && r_mode3 == MODE_UPPER)
        |-> (o_pix.out_alpha == 8'hFF || o_pix.out_alpha == 8'h00))
        else $error("upper vertex alpha not fixed");

endmodule
